/* hdl/ltc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltc_pkg
// Shared types and constants of the texture cache table.
// ----------------------------------------------------------------------------
package ltc_pkg;

    localparam int ENTRIES     = 256;
    localparam int NUM_BUCKETS = 64;    // power of two
    localparam int SLOT_W      = $clog2(ENTRIES);
    localparam int LINK_W      = SLOT_W + 1;
    localparam int BKT_W       = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;

    localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(ENTRIES);

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_DEL = 2'd1,
        OP_GET = 2'd2,
        OP_NOP = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2,
        ST_DUP  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HEAD,
        S_WALK,
        S_ALLOC,
        S_UPD,
        S_UPD2,
        S_OKEY,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] key;
        logic [31:0] handle_in;
        logic [23:0] bytes_in;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] handle_out;
        logic [31:0] total_bytes;
        logic [8:0]  entry_count;
        logic        oldest_valid;
        logic [15:0] oldest_key;
    } t_out;

endpackage

/* hdl/ltc_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltc_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ltc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/lru_keyed_texture_cache_table_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_keyed_texture_cache_table_unit
// Keyed texture table with hashed bucket chains and an LRU recency list.
// ----------------------------------------------------------------------------
// One operation is in flight at a time. An operation reads the bucket head
// (in the accepting cycle and the head state), then visits the chain one
// entry at a time, then runs its update steps (none on a miss of a get or a
// delete, a duplicate or a full table; a free slot is first popped from the
// free stack when one is free, and the least-recent key is refetched when
// the oldest entry changes) and then posts the result. A no-op skips the
// head read. The chain walk goes through the single read port of the entry
// memories; a stalled result holds the block. No clearing pass is needed
// after reset; the block takes a beat in the cycle after reset.
// ----------------------------------------------------------------------------
module lru_keyed_texture_cache_table_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    output logic         o_in_stall,
    input  ltc_pkg::t_in i_in,
    output logic         o_out_valid,
    input  logic         i_out_stall,
    output ltc_pkg::t_out o_out
);
    import ltc_pkg::*;

    t_state r_state, n_state;
    t_op    r_op, n_op;
    t_status r_status, n_status;
    logic [15:0]       r_key, n_key;
    logic [31:0]       r_hin, n_hin;
    logic [23:0]       r_bin, n_bin;
    logic [BKT_W-1:0]  r_bkt, n_bkt;
    logic [LINK_W-1:0] r_head, n_head;
    logic [SLOT_W-1:0] r_cur, n_cur;
    logic [LINK_W-1:0] r_prev, n_prev;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic [LINK_W-1:0] r_nxt, n_nxt;
    logic [LINK_W-1:0] r_nw, n_nw;
    logic [LINK_W-1:0] r_od, n_od;
    logic [31:0]       r_hout, n_hout;
    logic [23:0]       r_ebytes, n_ebytes;
    logic [LINK_W-1:0] r_newest, n_newest;
    logic [LINK_W-1:0] r_oldest, n_oldest;
    logic [15:0]       r_oldest_key, n_oldest_key;
    logic [LINK_W-1:0] r_count, n_count;
    logic [31:0]       r_total, n_total;
    logic [LINK_W-1:0] r_sp, n_sp;
    logic [LINK_W-1:0] r_fill, n_fill;
    logic [NUM_BUCKETS-1:0] r_bvld, n_bvld;
    logic              r_out_vld, n_out_vld;
    t_out              r_out, n_out;

    logic              w_accept;
    logic              w_out_load;
    logic [LINK_W-1:0] w_head;
    logic              w_hit;
    logic              w_miss;
    logic              w_cur_newest;
    logic [LINK_W-1:0] w_cur_link;
    logic [LINK_W-1:0] w_sp_dec;

    logic [SLOT_W-1:0] w_ent_raddr;
    logic [BKT_W-1:0]  w_bkt_raddr;

    logic [15:0]       key_rd;
    logic [31:0]       hdl_rd;
    logic [23:0]       byt_rd;
    logic [LINK_W-1:0] chn_rd, nwr_rd, old_rd, bkt_rd;
    logic [SLOT_W-1:0] fst_rd;

    logic              ent_we;
    logic              chn_we, nwr_we, old_we, bkt_we, fst_we;
    logic [SLOT_W-1:0] chn_wa, nwr_wa, old_wa;
    logic [LINK_W-1:0] chn_wd, nwr_wd, old_wd, bkt_wd;
    logic [BKT_W-1:0]  bkt_wa;

    ltc_ram #(.WIDTH(16), .DEPTH(ENTRIES)) u_key (
        .i_clk(i_clk), .i_we(ent_we), .i_waddr(r_slot), .i_wdata(r_key),
        .i_raddr(w_ent_raddr), .o_rdata(key_rd)
    );
    ltc_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_handle (
        .i_clk(i_clk), .i_we(ent_we), .i_waddr(r_slot), .i_wdata(r_hin),
        .i_raddr(w_ent_raddr), .o_rdata(hdl_rd)
    );
    ltc_ram #(.WIDTH(24), .DEPTH(ENTRIES)) u_bytes (
        .i_clk(i_clk), .i_we(ent_we), .i_waddr(r_slot), .i_wdata(r_bin),
        .i_raddr(w_ent_raddr), .o_rdata(byt_rd)
    );
    ltc_ram #(.WIDTH(LINK_W), .DEPTH(ENTRIES)) u_chain (
        .i_clk(i_clk), .i_we(chn_we), .i_waddr(chn_wa), .i_wdata(chn_wd),
        .i_raddr(w_ent_raddr), .o_rdata(chn_rd)
    );
    ltc_ram #(.WIDTH(LINK_W), .DEPTH(ENTRIES)) u_newer (
        .i_clk(i_clk), .i_we(nwr_we), .i_waddr(nwr_wa), .i_wdata(nwr_wd),
        .i_raddr(w_ent_raddr), .o_rdata(nwr_rd)
    );
    ltc_ram #(.WIDTH(LINK_W), .DEPTH(ENTRIES)) u_older (
        .i_clk(i_clk), .i_we(old_we), .i_waddr(old_wa), .i_wdata(old_wd),
        .i_raddr(w_ent_raddr), .o_rdata(old_rd)
    );
    ltc_ram #(.WIDTH(LINK_W), .DEPTH(NUM_BUCKETS)) u_bucket (
        .i_clk(i_clk), .i_we(bkt_we), .i_waddr(bkt_wa), .i_wdata(bkt_wd),
        .i_raddr(w_bkt_raddr), .o_rdata(bkt_rd)
    );
    ltc_ram #(.WIDTH(SLOT_W), .DEPTH(ENTRIES)) u_free (
        .i_clk(i_clk), .i_we(fst_we), .i_waddr(r_sp[SLOT_W-1:0]), .i_wdata(r_slot),
        .i_raddr(w_sp_dec[SLOT_W-1:0]), .o_rdata(fst_rd)
    );

    assign w_accept     = i_in_valid && !o_in_stall;
    assign w_out_load   = (r_state == S_DONE) && (!r_out_vld || !i_out_stall);
    assign w_head       = r_bvld[r_bkt] ? bkt_rd : NULL_LINK;
    assign w_cur_link   = {1'b0, r_cur};
    assign w_cur_newest = (w_cur_link == r_newest);
    assign w_hit        = (r_state == S_WALK) && (key_rd == r_key);
    assign w_miss       = ((r_state == S_HEAD) && (w_head == NULL_LINK)) ||
                          ((r_state == S_WALK) && !w_hit && (chn_rd == NULL_LINK));
    assign w_sp_dec     = r_sp - LINK_W'(1);
    assign w_bkt_raddr  = BKT_W'(i_in.key % NUM_BUCKETS);

    always_comb begin
        case (r_state)
            S_HEAD:  w_ent_raddr = w_head[SLOT_W-1:0];
            S_WALK:  w_ent_raddr = chn_rd[SLOT_W-1:0];
            default: w_ent_raddr = r_nw[SLOT_W-1:0];
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = (t_op'(i_in.op) == OP_NOP) ? S_DONE : S_HEAD;
                end
            end
            S_HEAD, S_WALK: begin
                if (w_miss) begin
                    if (r_op != OP_ADD) begin
                        n_state = S_DONE;
                    end else if (r_sp != '0) begin
                        n_state = S_ALLOC;
                    end else if (r_fill < LINK_W'(ENTRIES)) begin
                        n_state = S_UPD;
                    end else begin
                        n_state = S_DONE;
                    end
                end else if (w_hit) begin
                    case (r_op)
                        OP_DEL:  n_state = S_UPD;
                        OP_GET:  n_state = w_cur_newest ? S_DONE : S_UPD;
                        default: n_state = S_DONE;
                    endcase
                end else begin
                    n_state = S_WALK;
                end
            end
            S_ALLOC: n_state = S_UPD;
            S_UPD: begin
                case (r_op)
                    OP_DEL: begin
                        n_state = (r_od == NULL_LINK && r_nw != NULL_LINK) ? S_OKEY : S_DONE;
                    end
                    OP_GET:  n_state = S_UPD2;
                    default: n_state = S_DONE;
                endcase
            end
            S_UPD2:  n_state = (r_od == NULL_LINK) ? S_OKEY : S_DONE;
            S_OKEY:  n_state = S_DONE;
            S_DONE: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and memory writes
    always_comb begin
        n_op = r_op;         n_status = r_status;  n_key = r_key;
        n_hin = r_hin;       n_bin = r_bin;        n_bkt = r_bkt;
        n_head = r_head;     n_cur = r_cur;        n_prev = r_prev;
        n_slot = r_slot;     n_nxt = r_nxt;        n_nw = r_nw;
        n_od = r_od;         n_hout = r_hout;      n_ebytes = r_ebytes;
        n_newest = r_newest; n_oldest = r_oldest;  n_oldest_key = r_oldest_key;
        n_count = r_count;   n_total = r_total;    n_sp = r_sp;
        n_fill = r_fill;     n_bvld = r_bvld;      n_out = r_out;
        n_out_vld = r_out_vld && i_out_stall;

        ent_we = 1'b0;
        chn_we = 1'b0; chn_wa = r_slot; chn_wd = r_head;
        nwr_we = 1'b0; nwr_wa = r_slot; nwr_wd = {1'b0, r_slot};
        old_we = 1'b0; old_wa = r_slot; old_wd = r_newest;
        bkt_we = 1'b0; bkt_wa = r_bkt;  bkt_wd = {1'b0, r_slot};
        fst_we = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_op     = t_op'(i_in.op);
                    n_key    = i_in.key;
                    n_hin    = i_in.handle_in;
                    n_bin    = i_in.bytes_in;
                    n_bkt    = w_bkt_raddr;
                    n_status = ST_OK;
                    n_hout   = '0;
                end
            end
            S_HEAD, S_WALK: begin
                if (r_state == S_HEAD) begin
                    n_head = w_head;
                    n_cur  = w_head[SLOT_W-1:0];
                    n_prev = NULL_LINK;
                end
                if (w_hit) begin
                    n_slot   = r_cur;
                    n_nxt    = chn_rd;
                    n_nw     = w_cur_newest ? NULL_LINK : nwr_rd;
                    n_od     = (w_cur_link == r_oldest) ? NULL_LINK : old_rd;
                    n_ebytes = byt_rd;
                    if (r_op == OP_ADD) begin
                        n_status = ST_DUP;
                    end else begin
                        n_hout = hdl_rd;
                    end
                end else if (w_miss) begin
                    if (r_op != OP_ADD) begin
                        n_status = ST_MISS;
                    end else if (r_sp == '0) begin
                        if (r_fill < LINK_W'(ENTRIES)) begin
                            n_slot = r_fill[SLOT_W-1:0];
                            n_fill = r_fill + LINK_W'(1);
                        end else begin
                            n_status = ST_FULL;
                        end
                    end
                end else if (r_state == S_WALK) begin
                    n_prev = w_cur_link;
                    n_cur  = chn_rd[SLOT_W-1:0];
                end
            end
            S_ALLOC: begin
                n_slot = fst_rd;
                n_sp   = w_sp_dec;
            end
            S_UPD: begin
                case (r_op)
                    OP_ADD: begin
                        ent_we   = 1'b1;
                        chn_we   = 1'b1;
                        bkt_we   = 1'b1;
                        n_bvld[r_bkt] = 1'b1;
                        old_we   = 1'b1;
                        if (r_newest != NULL_LINK) begin
                            nwr_we = 1'b1;
                            nwr_wa = r_newest[SLOT_W-1:0];
                        end else begin
                            n_oldest     = {1'b0, r_slot};
                            n_oldest_key = r_key;
                        end
                        n_newest = {1'b0, r_slot};
                        n_total  = r_total + 32'(r_bin);
                        n_count  = r_count + LINK_W'(1);
                    end
                    OP_DEL: begin
                        if (r_prev != NULL_LINK) begin
                            chn_we = 1'b1;
                            chn_wa = r_prev[SLOT_W-1:0];
                            chn_wd = r_nxt;
                        end else begin
                            bkt_we = 1'b1;
                            bkt_wd = r_nxt;
                            n_bvld[r_bkt] = 1'b1;
                        end
                        if (r_nw != NULL_LINK) begin
                            old_we = 1'b1;
                            old_wa = r_nw[SLOT_W-1:0];
                            old_wd = r_od;
                        end else begin
                            n_newest = r_od;
                        end
                        if (r_od != NULL_LINK) begin
                            nwr_we = 1'b1;
                            nwr_wa = r_od[SLOT_W-1:0];
                            nwr_wd = r_nw;
                        end else begin
                            n_oldest = r_nw;
                        end
                        fst_we  = 1'b1;
                        n_sp    = r_sp + LINK_W'(1);
                        n_total = r_total - 32'(r_ebytes);
                        n_count = r_count - LINK_W'(1);
                    end
                    default: begin
                        // get, first half: unlink
                        old_we = 1'b1;
                        old_wa = r_nw[SLOT_W-1:0];
                        old_wd = r_od;
                        if (r_od != NULL_LINK) begin
                            nwr_we = 1'b1;
                            nwr_wa = r_od[SLOT_W-1:0];
                            nwr_wd = r_nw;
                        end else begin
                            n_oldest = r_nw;
                        end
                    end
                endcase
            end
            S_UPD2: begin
                old_we   = 1'b1;
                old_wd   = r_newest;
                nwr_we   = 1'b1;
                nwr_wa   = r_newest[SLOT_W-1:0];
                n_newest = {1'b0, r_slot};
            end
            S_OKEY: begin
                n_oldest_key = key_rd;
            end
            S_DONE: begin
                if (w_out_load) begin
                    n_out_vld           = 1'b1;
                    n_out.status        = r_status;
                    n_out.handle_out    = r_hout;
                    n_out.total_bytes   = r_total;
                    n_out.entry_count   = 9'(r_count);
                    n_out.oldest_valid  = (r_oldest != NULL_LINK);
                    n_out.oldest_key    = (r_oldest != NULL_LINK) ? r_oldest_key : 16'd0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_newest  <= NULL_LINK;
            r_oldest  <= NULL_LINK;
            r_count   <= '0;
            r_total   <= '0;
            r_sp      <= '0;
            r_fill    <= '0;
            r_bvld    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_newest  <= n_newest;
            r_oldest  <= n_oldest;
            r_count   <= n_count;
            r_total   <= n_total;
            r_sp      <= n_sp;
            r_fill    <= n_fill;
            r_bvld    <= n_bvld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_status     <= n_status;
        r_key        <= n_key;
        r_hin        <= n_hin;
        r_bin        <= n_bin;
        r_bkt        <= n_bkt;
        r_head       <= n_head;
        r_cur        <= n_cur;
        r_prev       <= n_prev;
        r_slot       <= n_slot;
        r_nxt        <= n_nxt;
        r_nw         <= n_nw;
        r_od         <= n_od;
        r_hout       <= n_hout;
        r_ebytes     <= n_ebytes;
        r_oldest_key <= n_oldest_key;
        r_out        <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= LINK_W'(ENTRIES))
        else $error("entry count above capacity");

    a_slot_balance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> ((10'(r_count) + 10'(r_sp)) == 10'(r_fill)))
        else $error("free stack and fill mark disagree with entry count");

    a_list_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_oldest == NULL_LINK) == (r_newest == NULL_LINK))
        else $error("recency list ends disagree");

    a_empty_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) == (r_oldest == NULL_LINK))
        else $error("recency list and entry count disagree");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state != S_IDLE))
        else $error("accepted beat left no work in flight");
`endif

endmodule
